// ----- design/spq_pkg.sv -----
// Shared types and codes for the stable priority queue.
// No dependencies; imported by spq_ram and stable_priority_queue_top.
package spq_pkg;

   localparam int ID_W   = 16;
   localparam int PRIO_W = 8;
   localparam int FILL_W = 5;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

// ----- design/spq_ram.sv -----
// Entry store of the priority queue: one write port, one read port,
// read data registered and held while rd_en is low. Depends on spq_pkg.
module spq_ram
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/stable_priority_queue_top.sv -----
// Stable priority queue, top level.
// Depends on spq_pkg and spq_ram.
//
//   The req_ channel carries one request word: req_type (insert, remove head,
//   search by id), req_item_id and req_item_priority. The rsp_ channel returns
//   exactly one result word per request: status, id and priority of the
//   removed or found entry (zero otherwise) and the fill level afterwards.
//   Entries stay sorted in service order in a RAM with registered read data;
//   a lower priority leaves first and equal priorities leave in arrival order.
//   One request is worked on at a time, one entry per cycle; req_stall is high
//   until its result word is loaded. The work per request after it is accepted:
//     insert : shift held entries with priority above the new one up, then place it
//     remove : read the head, then shift the remaining entries towards the head
//     search : scan in service order up to the first match or the last entry
//     full / empty / unknown request : straight to the result word
//   req_stall falls in the same cycle as rsp_valid rises.
//   Synchronous active-high reset empties the queue; stored entries are
//   left as they are and never read before being written again. While
//   rsp_stall is high the result word holds; a finished request waits in
//   its done state, and a new request is taken once the block is idle.
module stable_priority_queue_top
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [ID_W-1:0]   req_item_id,
   input  logic [PRIO_W-1:0] req_item_priority,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_out_id,
   output logic [PRIO_W-1:0] rsp_out_priority,
   output logic [FILL_W-1:0] rsp_fill_level
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INS   = 3'd1;   // walk from the tail, shifting up
   localparam logic [2:0] S_PLACE = 3'd2;   // write the new entry at its slot
   localparam logic [2:0] S_POP   = 3'd3;   // capture the head
   localparam logic [2:0] S_SHIFT = 3'd4;   // close the gap at the head
   localparam logic [2:0] S_SRCH  = 3'd5;   // scan in service order
   localparam logic [2:0] S_DONE  = 3'd6;   // hand the result word over

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [ID_W-1:0]   key_id_ff, key_id_in;
   logic [PRIO_W-1:0] key_pr_ff, key_pr_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [PRIO_W-1:0] res_pr_ff, res_pr_in;

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_st_ff, out_st_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [PRIO_W-1:0] out_pr_ff, out_pr_in;
   logic [FILL_W-1:0] out_fill_ff, out_fill_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data;

   logic              accept;
   logic              out_free;
   logic [CNT_W-1:0]  cnt_dec;
   logic [CNT_W-1:0]  pos_next_cnt;
   logic [31:0]       cnt_wide;

   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != S_IDLE);
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign cnt_dec      = cnt_ff - CNT_W'(1);
   assign pos_next_cnt = CNT_W'(pos_ff) + CNT_W'(1);
   assign cnt_wide     = 32'(cnt_ff);

   spq_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      key_id_in    = key_id_ff;
      key_pr_in    = key_pr_ff;
      res_st_in    = res_st_ff;
      res_id_in    = res_id_ff;
      res_pr_in    = res_pr_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_st_in    = out_st_ff;
      out_id_in    = out_id_ff;
      out_pr_in    = out_pr_ff;
      out_fill_in  = out_fill_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = '{id: key_id_ff, prio: key_pr_ff};
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_id_in = req_item_id;
               key_pr_in = req_item_priority;
               res_st_in = ST_OK;
               res_id_in = '0;
               res_pr_in = '0;
               state_in  = S_DONE;
               case (req_type)
                  REQ_INSERT: begin
                     if (cnt_ff >= CNT_W'(CAPACITY)) begin
                        res_st_in = ST_FULL;
                     end else if (cnt_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_PLACE;
                     end else begin
                        // start at the tail: new slot is count, compare count-1
                        pos_in   = cnt_ff[IDX_W-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = cnt_dec[IDX_W-1:0];
                        state_in = S_INS;
                     end
                  end
                  REQ_REMOVE: begin
                     if (cnt_ff == '0) begin
                        res_st_in = ST_EMPTY;
                     end else begin
                        pos_in   = '0;
                        rd_en    = 1'b1;
                        state_in = S_POP;
                     end
                  end
                  REQ_SEARCH: begin
                     if (cnt_ff == '0) begin
                        res_st_in = ST_NOTFOUND;
                     end else begin
                        pos_in   = '0;
                        rd_en    = 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_INS: begin
            // rd_data holds the entry just below the free slot
            if (rd_data.prio > key_pr_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = pos_ff - IDX_W'(1);
               if (pos_ff == IDX_W'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - IDX_W'(2);
               end
            end else begin
               wr_en    = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_PLACE: begin
            wr_en    = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         S_POP: begin
            res_id_in = rd_data.id;
            res_pr_in = rd_data.prio;
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = cnt_dec;
               state_in = S_DONE;
            end else begin
               pos_in   = IDX_W'(1);
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(1);
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            // move slot pos down by one
            wr_en   = 1'b1;
            wr_addr = pos_ff - IDX_W'(1);
            wr_data = rd_data;
            if (pos_next_cnt == cnt_ff) begin
               cnt_in   = cnt_dec;
               state_in = S_DONE;
            end else begin
               pos_in  = pos_ff + IDX_W'(1);
               rd_en   = 1'b1;
               rd_addr = pos_ff + IDX_W'(1);
            end
         end

         S_SRCH: begin
            if (rd_data.id == key_id_ff) begin
               res_id_in = rd_data.id;
               res_pr_in = rd_data.prio;
               state_in  = S_DONE;
            end else if (pos_next_cnt == cnt_ff) begin
               res_st_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               pos_in  = pos_ff + IDX_W'(1);
               rd_en   = 1'b1;
               rd_addr = pos_ff + IDX_W'(1);
            end
         end

         S_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_st_in    = res_st_ff;
               out_id_in    = res_id_ff;
               out_pr_in    = res_pr_ff;
               out_fill_in  = cnt_wide[FILL_W-1:0];
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff      <= pos_in;
      key_id_ff   <= key_id_in;
      key_pr_ff   <= key_pr_in;
      res_st_ff   <= res_st_in;
      res_id_ff   <= res_id_in;
      res_pr_ff   <= res_pr_in;
      out_st_ff   <= out_st_in;
      out_id_ff   <= out_id_in;
      out_pr_ff   <= out_pr_in;
      out_fill_ff <= out_fill_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_st_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_priority = out_pr_ff;
   assign rsp_fill_level   = out_fill_ff;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for stable_priority_queue_top.
// Depends on spq_pkg and the RTL; mirrors the sorted store in a local predictor
// and compares every result word with the prediction made when its request was taken.
module testbench;
   import spq_pkg::*;

   localparam int CAPACITY = 16;
   // request code that the block has to ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // give up after this many cycles without a single handshake
   localparam int WATCHDOG_LIMIT = 2000;
   // worst insert or remove walk plus the result register, with margin
   localparam int TAIL_CYCLES = CAPACITY + 8;

   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [FILL_W-1:0] fill;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = REQ_INSERT;
   logic [ID_W-1:0]   req_item_id = '0;
   logic [PRIO_W-1:0] req_item_priority = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_out_id;
   logic [PRIO_W-1:0] rsp_out_priority;
   logic [FILL_W-1:0] rsp_fill_level;

   // predictor state: entries in service order, head at index zero
   entry_type   held[CAPACITY];
   int          held_count = 0;
   outcome_type awaited_outcomes[$];

   // idle rates in percent, changed by the tests
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   int failures = 0;
   int words_sent = 0;
   int words_checked = 0;
   int full_seen = 0;
   int empty_seen = 0;
   int miss_seen = 0;

   stable_priority_queue_top #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_item_id(req_item_id),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_id(rsp_out_id),
      .rsp_out_priority(rsp_out_priority),
      .rsp_fill_level(rsp_fill_level)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one request to the local store and return the word it must produce.
   // An insert lands after every entry of equal or lower priority, so ties leave
   // in arrival order; a search reports the first match in service order.
   function automatic outcome_type serve_request(input logic [1:0] kind,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [PRIO_W-1:0] prio);
      outcome_type res;
      int          pos;
      bit          found;
      res = '0;
      found = 1'b0;
      case (kind)
         REQ_INSERT: begin
            if (held_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < held_count && held[pos].prio <= prio) pos++;
               for (int i = held_count; i > pos; i--) held[i] = held[i-1];
               held[pos].id = id;
               held[pos].prio = prio;
               held_count++;
               res.status = ST_OK;
            end
         end
         REQ_REMOVE: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_OK;
               res.id = held[0].id;
               res.prio = held[0].prio;
               for (int i = 1; i < held_count; i++) held[i-1] = held[i];
               held_count--;
            end
         end
         REQ_SEARCH: begin
            res.status = ST_NOTFOUND;
            for (int i = 0; i < held_count; i++) begin
               if (!found && held[i].id == id) begin
                  found = 1'b1;
                  res.status = ST_OK;
                  res.id = held[i].id;
                  res.prio = held[i].prio;
               end
            end
         end
         default: res.status = ST_OK;
      endcase
      res.fill = held_count[FILL_W-1:0];
      return res;
   endfunction

   // Idle with a chance of pct percent: mostly short runs, now and then a long one.
   function automatic int idle_run(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   // Offer one request word, hold it until taken, then record its outcome.
   // Entered and left at a falling edge; valid stays high for a back-to-back word.
   task automatic send_word(input logic [1:0] kind, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio);
      int gap;
      gap = idle_run(gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_item_id <= id;
      req_item_priority <= prio;
      do @(posedge clock); while (req_stall);
      awaited_outcomes.push_back(serve_request(kind, id, prio));
      words_sent++;
      @(negedge clock);
   endtask

   // Ids mostly from a small pool so that duplicates and search hits are common.
   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 60) return ID_W'($urandom_range(15));
      if (r < 70) return ($urandom_range(1) != 0) ? '1 : '0;
      return ID_W'($urandom);
   endfunction

   // Priorities mostly from a narrow band so that ties are frequent.
   function automatic logic [PRIO_W-1:0] pick_prio();
      int r;
      r = $urandom_range(99);
      if (r < 50) return PRIO_W'($urandom_range(3));
      if (r < 60) return ($urandom_range(1) != 0) ? '1 : '0;
      return PRIO_W'($urandom);
   endfunction

   // One random request; insert_pct steers the fill level up or down.
   task automatic random_request(input int insert_pct);
      int                r;
      logic [1:0]        kind;
      logic [ID_W-1:0]   id;
      r = $urandom_range(99);
      if (r < 4) kind = REQ_UNUSED;
      else if (r < 4 + insert_pct) kind = REQ_INSERT;
      else if (r < 4 + insert_pct + (96 - insert_pct) / 2) kind = REQ_REMOVE;
      else kind = REQ_SEARCH;
      id = pick_id();
      // aim most searches at something that is held, anywhere in the order
      if (kind == REQ_SEARCH && held_count > 0 && $urandom_range(99) < 60)
         id = held[$urandom_range(held_count - 1)].id;
      send_word(kind, id, pick_prio());
   endtask

   task automatic test_empty_queue();
      send_word(REQ_REMOVE, 16'h1234, 8'h56);
      send_word(REQ_SEARCH, '1, '1);
      send_word(REQ_UNUSED, '1, '1);
   endtask

   // Fill to capacity with extreme ids and priorities, ties and a duplicate id,
   // then try one insert too many.
   task automatic test_fill_and_overflow();
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      for (int k = 0; k < CAPACITY; k++) begin
         if (k == 0) id = '0;
         else if (k == 1) id = '1;
         else if (k % 3 == 0) id = 16'h00A5;
         else id = ID_W'(16'h1000 + k);
         if (k == 2) prio = '0;
         else if (k == 3) prio = '1;
         else prio = PRIO_W'((k % 5) * 8);
         send_word(REQ_INSERT, id, prio);
      end
      send_word(REQ_INSERT, '1, '0);
   endtask

   task automatic test_search_and_pop();
      send_word(REQ_SEARCH, 16'h00A5, 8'h00);
      send_word(REQ_SEARCH, 16'hBEEF, 8'hFF);
      send_word(REQ_UNUSED, 16'h5A5A, 8'hA5);
      send_word(REQ_REMOVE, '0, '0);
      send_word(REQ_REMOVE, '1, '1);
   endtask

   // Alternate filling and draining blocks so full and empty come round often.
   task automatic test_random_mix();
      gap_pct = 25;
      stall_pct = 25;
      for (int b = 0; b < 10; b++)
         for (int n = 0; n < 100; n++) random_request((b % 2 == 0) ? 70 : 15);
   endtask

   task automatic test_back_to_back();
      gap_pct = 0;
      stall_pct = 0;
      repeat (400) random_request(45);
   endtask

   task automatic test_heavy_backpressure();
      gap_pct = 60;
      stall_pct = 60;
      for (int b = 0; b < 4; b++)
         for (int n = 0; n < 100; n++) random_request((b % 2 == 0) ? 60 : 25);
   endtask

   // Result side stall: change at the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = idle_run(stall_pct);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Check each taken result word against the oldest outcome still owed.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outcomes.size() == 0) begin
            $error("result word with nothing owed: status %0d id %h priority %h fill %0d",
                   rsp_status, rsp_out_id, rsp_out_priority, rsp_fill_level);
            failures++;
         end else begin
            want = awaited_outcomes.pop_front();
            words_checked++;
            if (rsp_status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_out_id != want.id) begin
               $error("out_id: expected %h, got %h", want.id, rsp_out_id);
               failures++;
            end
            if (rsp_out_priority != want.prio) begin
               $error("out_priority: expected %h, got %h", want.prio, rsp_out_priority);
               failures++;
            end
            if (rsp_fill_level != want.fill) begin
               $error("fill_level: expected %0d, got %0d", want.fill, rsp_fill_level);
               failures++;
            end
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_EMPTY) empty_seen++;
            if (want.status == ST_NOTFOUND) miss_seen++;
         end
      end
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
      end
      $display("[stable_priority_queue_top] ERROR");
      $finish;
   end

   initial begin
      // hold reset, then release it at a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_pct = 20;
      stall_pct = 20;
      test_empty_queue();
      test_fill_and_overflow();
      test_search_and_pop();
      test_random_mix();
      test_back_to_back();
      test_heavy_backpressure();
      req_valid <= 1'b0;

      // drain: wait for every owed word, then allow for any late stray one
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_outcomes.size() != 0) begin
         $error("%0d result words never arrived", awaited_outcomes.size());
         failures++;
      end

      $display("Sent %0d request words and checked %0d result words.",
               words_sent, words_checked);
      $display("Queue-full %0d, queue-empty %0d, id-not-found %0d results seen.",
               full_seen, empty_seen, miss_seen);
      if (failures == 0) begin
         $display("[stable_priority_queue_top] OK");
      end else begin
         $display("[stable_priority_queue_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/spq_pkg.sv
design/spq_ram.sv
design/stable_priority_queue_top.sv
tb/testbench.sv
